// File: sv/timed_event_queue_assert.svh
// Assertion helpers shared by the queue RTL.
`ifndef TIMED_EVENT_QUEUE_ASSERT_SVH
`define TIMED_EVENT_QUEUE_ASSERT_SVH

// A property that must hold on every clock edge outside reset.
`define TEQ_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// A property whose consequence must hold in the cycle after its trigger.
`define TEQ_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/teq_pkg.sv
`default_nettype none

package teq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int TIME_BITS   = 32;
    localparam int TAG_BITS    = 16;
    localparam int OWNER_BITS  = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;

    localparam logic [OP_W-1:0] OP_INS_TIMED = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_NOW   = 3'd1;
    localparam logic [OP_W-1:0] OP_POP       = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd3;
    localparam logic [OP_W-1:0] OP_SET_TIME  = 3'd4;
    localparam logic [OP_W-1:0] OP_REBASE    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

    typedef struct packed {
        logic [TIME_BITS-1:0]  tm;
        logic [TAG_BITS-1:0]   tag;
        logic [OWNER_BITS-1:0] owner;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

// File: sv/teq_ram.sv
`default_nettype none

module teq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/timed_event_queue.sv
`default_nettype none
// Time-ordered event queue holding up to QUEUE_DEPTH entries of time, tag and owner.
// A request is taken at a rising edge where start is high and busy is low. Each
// request produces one result, shown for exactly one cycle while o_done is high;
// the receiver cannot stall, so the result must be captured in that cycle.
// Entries live in a single-port-read RAM arranged as a ring behind a head pointer,
// and one time subtractor under a small sequencer does every compare and rebase.
// Steps after the accepting edge, with n entries held:
//   set time, unused codes, full insert, and requests on an empty queue: done from idle.
//   pop: head read, due compare, then a current-time compare when the head is due;
//   a head that is not due ends after the due compare.
//   insert: walks back from the tail, shifting each later entry up by one, then writes.
//   remove and rebase: all n entries visited in order, one RAM entry per cycle.
// The RAM read port, one entry per cycle, paces these steps; busy stays high
// for the whole request, so requests are handled strictly one at a time.
// Synchronous active-low reset empties the queue (head, count) and clears the
// current time. RAM contents are not cleared; only slots below the count are read.
`include "timed_event_queue_assert.svh"

module timed_event_queue import teq_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output      logic                  busy,
    input  wire logic [OP_W-1:0]       i_opcode,
    input  wire logic [TIME_BITS-1:0]  i_event_time,
    input  wire logic [TAG_BITS-1:0]   i_event_tag,
    input  wire logic [OWNER_BITS-1:0] i_owner_id,
    output      logic                  o_done,
    output      logic [STATUS_W-1:0]   o_status,
    output      logic [TAG_BITS-1:0]   o_popped_tag,
    output      logic [TIME_BITS-1:0]  o_popped_time,
    output      logic [OWNER_BITS-1:0] o_popped_owner,
    output      logic [CNT_W-1:0]      o_removed_count,
    output      logic [TIME_BITS-1:0]  o_now_time,
    output      logic [CNT_W-1:0]      o_occupancy
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_PUT  = 3'd2;
    localparam logic [2:0] S_POP  = 3'd3;
    localparam logic [2:0] S_POP2 = 3'd4;
    localparam logic [2:0] S_REM  = 3'd5;
    localparam logic [2:0] S_REB  = 3'd6;

    logic [2:0]            r_state,   n_state;
    logic [IDX_W-1:0]      r_head,    n_head;
    logic [CNT_W-1:0]      r_count,   n_count;
    logic [TIME_BITS-1:0]  r_now,     n_now;
    logic                  r_done,    n_done;

    // Request fields held for the length of a request.
    logic [TIME_BITS-1:0]  r_time,    n_time;
    logic [TAG_BITS-1:0]   r_tag,     n_tag;
    logic [OWNER_BITS-1:0] r_owner,   n_owner;
    // Scan index (logical, from the head) and compaction write index.
    logic [CNT_W-1:0]      r_k,       n_k;
    logic [CNT_W-1:0]      r_w,       n_w;
    logic [TIME_BITS-1:0]  r_base,    n_base;

    // Result registers.
    logic [STATUS_W-1:0]   r_status,  n_status;
    logic [TAG_BITS-1:0]   r_ptag,    n_ptag;
    logic [TIME_BITS-1:0]  r_ptime,   n_ptime;
    logic [OWNER_BITS-1:0] r_powner,  n_powner;
    logic [CNT_W-1:0]      r_removed, n_removed;

    logic                  accept;
    logic                  ram_we;
    logic [CNT_W-1:0]      wr_log;
    logic [CNT_W-1:0]      rd_log;
    t_entry                wr_data;
    t_entry                rd_data;
    logic [ENTRY_W-1:0]    ram_q;
    t_entry                new_entry;
    logic [TIME_BITS-1:0]  ins_time;

    // The shared time unit: computes b - a, and flags b < a.
    logic [TIME_BITS-1:0]  alu_a;
    logic [TIME_BITS-1:0]  alu_b;
    logic [TIME_BITS:0]    alu_diff;
    logic                  alu_lt;

    logic                  owner_hit;
    logic                  scan_last;
    logic [CNT_W-1:0]      w_step;

    // Terms used by the checks at the end of the module.
    logic                  ins_full;
    logic                  full_ack;
    logic                  pop_due;

    // Map a logical position, counted from the head, onto a RAM slot in the ring.
    function automatic logic [IDX_W-1:0] f_phys(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] pos);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, pos[IDX_W-1:0]};
        if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
            sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    teq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (f_phys(r_head, wr_log)),
        .i_wdata (wr_data),
        .i_raddr (f_phys(r_head, rd_log)),
        .o_rdata (ram_q)
    );

    assign rd_data   = t_entry'(ram_q);
    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign ins_time  = (i_opcode == OP_INS_TIMED) ? i_event_time : r_now;
    assign new_entry = '{tm: r_time, tag: r_tag, owner: r_owner};
    assign owner_hit = (rd_data.owner == r_owner);
    assign scan_last = (r_k == r_count - CNT_W'(1));
    assign w_step    = owner_hit ? r_w : r_w + CNT_W'(1);

    // Operand selection for the time unit, by sequencer state.
    always_comb begin
        alu_a = rd_data.tm;
        alu_b = r_time;
        unique case (r_state)
            S_POP2: begin
                alu_a = r_ptime;
                alu_b = r_now;
            end
            S_REB: begin
                // The head entry is the base of the rebase and comes first.
                alu_a = (r_k == '0) ? rd_data.tm : r_base;
                alu_b = rd_data.tm;
            end
            default: begin
                alu_a = rd_data.tm;
                alu_b = r_time;
            end
        endcase
    end

    assign alu_diff = {1'b0, alu_b} - {1'b0, alu_a};
    assign alu_lt   = alu_diff[TIME_BITS];

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_now     = r_now;
        n_done    = 1'b0;
        n_time    = r_time;
        n_tag     = r_tag;
        n_owner   = r_owner;
        n_k       = r_k;
        n_w       = r_w;
        n_base    = r_base;
        n_status  = r_status;
        n_ptag    = r_ptag;
        n_ptime   = r_ptime;
        n_powner  = r_powner;
        n_removed = r_removed;
        ram_we    = 1'b0;
        wr_log    = '0;
        wr_data   = new_entry;
        rd_log    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_time    = i_event_time;
                    n_tag     = i_event_tag;
                    n_owner   = i_owner_id;
                    n_status  = ST_OK;
                    n_ptag    = '0;
                    n_ptime   = '0;
                    n_powner  = '0;
                    n_removed = '0;
                    n_k       = '0;
                    n_w       = '0;
                    unique case (i_opcode)
                        OP_INS_TIMED, OP_INS_NOW: begin
                            n_time = ins_time;
                            if (r_count >= CNT_W'(QUEUE_DEPTH)) begin
                                n_status = ST_FULL;
                                n_done   = 1'b1;
                            end else if (r_count == '0) begin
                                ram_we  = 1'b1;
                                wr_log  = '0;
                                wr_data = '{tm: ins_time, tag: i_event_tag, owner: i_owner_id};
                                n_count = CNT_W'(1);
                                n_done  = 1'b1;
                            end else begin
                                // Walk back from the tail, shifting later entries up.
                                rd_log  = r_count - CNT_W'(1);
                                n_k     = r_count;
                                n_state = S_INS;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_NONE;
                                n_now    = i_event_time;
                                n_done   = 1'b1;
                            end else begin
                                rd_log  = '0;
                                n_state = S_POP;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_count == '0) begin
                                n_done = 1'b1;
                            end else begin
                                rd_log  = '0;
                                n_state = S_REM;
                            end
                        end
                        OP_SET_TIME: begin
                            n_now  = i_event_time;
                            n_done = 1'b1;
                        end
                        OP_REBASE: begin
                            n_now = '0;
                            if (r_count == '0) begin
                                n_done = 1'b1;
                            end else begin
                                rd_log  = '0;
                                n_state = S_REB;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end

            S_INS: begin
                // rd_data is the entry just below slot r_k.
                ram_we = 1'b1;
                wr_log = r_k;
                if (alu_lt) begin
                    wr_data = rd_data;
                    n_k     = r_k - CNT_W'(1);
                    if (r_k == CNT_W'(1)) begin
                        n_state = S_PUT;
                    end else begin
                        rd_log = r_k - CNT_W'(2);
                    end
                end else begin
                    wr_data = new_entry;
                    n_count = r_count + CNT_W'(1);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_PUT: begin
                ram_we  = 1'b1;
                wr_log  = r_k;
                wr_data = new_entry;
                n_count = r_count + CNT_W'(1);
                n_done  = 1'b1;
                n_state = S_IDLE;
            end

            S_POP: begin
                if (!alu_lt) begin
                    n_ptag   = rd_data.tag;
                    n_ptime  = rd_data.tm;
                    n_powner = rd_data.owner;
                    n_head   = f_phys(r_head, CNT_W'(1));
                    n_count  = r_count - CNT_W'(1);
                    n_state  = S_POP2;
                end else begin
                    n_status = ST_NONE;
                    n_now    = r_time;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            S_POP2: begin
                // On a due pop the current time only moves forward.
                if (alu_lt) begin
                    n_now = r_ptime;
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end

            S_REM: begin
                if (owner_hit) begin
                    n_removed = r_removed + CNT_W'(1);
                end else begin
                    ram_we  = 1'b1;
                    wr_log  = r_w;
                    wr_data = rd_data;
                end
                n_w = w_step;
                if (scan_last) begin
                    n_count = w_step;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    rd_log = r_k + CNT_W'(1);
                    n_k    = r_k + CNT_W'(1);
                end
            end

            S_REB: begin
                if (r_k == '0) begin
                    n_base = rd_data.tm;
                end
                ram_we  = 1'b1;
                wr_log  = r_k;
                wr_data = '{tm: alu_diff[TIME_BITS-1:0], tag: rd_data.tag,
                            owner: rd_data.owner};
                if (scan_last) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    rd_log = r_k + CNT_W'(1);
                    n_k    = r_k + CNT_W'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_now   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_now   <= n_now;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_time    <= n_time;
        r_tag     <= n_tag;
        r_owner   <= n_owner;
        r_k       <= n_k;
        r_w       <= n_w;
        r_base    <= n_base;
        r_status  <= n_status;
        r_ptag    <= n_ptag;
        r_ptime   <= n_ptime;
        r_powner  <= n_powner;
        r_removed <= n_removed;
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_popped_tag    = r_ptag;
    assign o_popped_time   = r_ptime;
    assign o_popped_owner  = r_powner;
    assign o_removed_count = r_removed;
    assign o_now_time      = r_now;
    assign o_occupancy     = r_count;

    assign ins_full = accept && ((i_opcode == OP_INS_TIMED) || (i_opcode == OP_INS_NOW))
                      && (r_count == CNT_W'(QUEUE_DEPTH));
    assign full_ack = o_done && (o_status == ST_FULL);
    assign pop_due  = (r_state == S_POP) && !alu_lt;

    `TEQ_ALWAYS(a_count_bound, r_count <= CNT_W'(QUEUE_DEPTH), "occupancy above depth")
    `TEQ_NEXT(a_accept_progress, accept, busy || o_done, "request neither running nor done")
    `TEQ_NEXT(a_full_drop, ins_full, full_ack && $stable(r_count), "full insert not dropped")
    `TEQ_NEXT(a_pop_count, pop_due, r_count == $past(r_count) - CNT_W'(1), "pop kept its entry")
    `TEQ_ALWAYS(a_compact_order, r_state != S_REM || r_w <= r_k, "compaction write ahead of scan")

endmodule

`default_nettype wire

// File: verif/tb_timed_event_queue.sv
`timescale 1ns / 1ps

module tb_timed_event_queue import teq_pkg::*; ();

    // Opcodes 6 and 7 have no function. The block must answer them like a no-op.
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    // The longest requests, such as remove or rebase on a full queue, visit every entry once.
    // This settle time covers them with room to spare.
    localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 8;

    // One expected result, with one member for each result port.
    typedef struct {
        logic [STATUS_W-1:0]   status;
        logic [TAG_BITS-1:0]   tag;
        logic [TIME_BITS-1:0]  tm;
        logic [OWNER_BITS-1:0] owner;
        logic [CNT_W-1:0]      removed;
        logic [TIME_BITS-1:0]  now;
        logic [CNT_W-1:0]      occ;
    } t_queue_result;

    // Every input of the block has a known value from time zero on.
    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  start        = 1'b0;
    logic [OP_W-1:0]       i_opcode     = '0;
    logic [TIME_BITS-1:0]  i_event_time = '0;
    logic [TAG_BITS-1:0]   i_event_tag  = '0;
    logic [OWNER_BITS-1:0] i_owner_id   = '0;

    logic                  busy;
    logic                  o_done;
    logic [STATUS_W-1:0]   o_status;
    logic [TAG_BITS-1:0]   o_popped_tag;
    logic [TIME_BITS-1:0]  o_popped_time;
    logic [OWNER_BITS-1:0] o_popped_owner;
    logic [CNT_W-1:0]      o_removed_count;
    logic [TIME_BITS-1:0]  o_now_time;
    logic [CNT_W-1:0]      o_occupancy;

    // This is a software copy of the queue. Slots below sched_count are held in time
    // order, and sched_now is the current time.
    t_entry               sched_slots [QUEUE_DEPTH];
    int                   sched_count = 0;
    logic [TIME_BITS-1:0] sched_now   = '0;

    // These are the results still to come, oldest first.
    t_queue_result pending_results [$];

    // The percentage of cycles in which the sender holds back before a request.
    int idle_pct = 0;
    int failures = 0;

    // These owners are used over and over, so that removes find entries to delete.
    // The all-zero owner and the all-ones owner are among them.
    logic [OWNER_BITS-1:0] owner_pool [6];

    timed_event_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_event_time    (i_event_time),
        .i_event_tag     (i_event_tag),
        .i_owner_id      (i_owner_id),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_popped_tag    (o_popped_tag),
        .o_popped_time   (o_popped_time),
        .o_popped_owner  (o_popped_owner),
        .o_removed_count (o_removed_count),
        .o_now_time      (o_now_time),
        .o_occupancy     (o_occupancy)
    );

    always #5 i_clk = ~i_clk;

    // Apply one accepted request to the software queue and return the result
    // that the block has to report for it.
    task automatic schedule_request(input logic [OP_W-1:0] op,
                                    input logic [TIME_BITS-1:0] tm,
                                    input logic [TAG_BITS-1:0] tag,
                                    input logic [OWNER_BITS-1:0] owner,
                                    output t_queue_result res);
        t_entry               fresh;
        int                   pos;
        int                   kept;
        int                   dropped;
        logic [TIME_BITS-1:0] head_time;

        res = '{default: '0};
        res.status = ST_OK;
        dropped = 0;
        case (op)
            OP_INS_TIMED, OP_INS_NOW: begin
                if (sched_count >= QUEUE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    fresh.tm    = (op == OP_INS_NOW) ? sched_now : tm;
                    fresh.tag   = tag;
                    fresh.owner = owner;
                    // The new entry goes behind every entry with an equal or
                    // earlier time. This keeps entries with the same time in
                    // arrival order.
                    pos = 0;
                    while (pos < sched_count && sched_slots[pos].tm <= fresh.tm)
                        pos++;
                    for (int k = sched_count; k > pos; k--)
                        sched_slots[k] = sched_slots[k - 1];
                    sched_slots[pos] = fresh;
                    sched_count++;
                end
            end
            OP_POP: begin
                if (sched_count > 0 && sched_slots[0].tm <= tm) begin
                    res.tag   = sched_slots[0].tag;
                    res.tm    = sched_slots[0].tm;
                    res.owner = sched_slots[0].owner;
                    for (int k = 1; k < sched_count; k++)
                        sched_slots[k - 1] = sched_slots[k];
                    sched_count--;
                    // A pop never moves the current time backwards.
                    if (res.tm > sched_now)
                        sched_now = res.tm;
                end else begin
                    // Nothing is due. The clock jumps to the target, even if
                    // the target is earlier than the current time.
                    res.status = ST_NONE;
                    sched_now  = tm;
                end
            end
            OP_REMOVE: begin
                kept = 0;
                for (int k = 0; k < sched_count; k++) begin
                    if (sched_slots[k].owner == owner) begin
                        dropped++;
                    end else begin
                        sched_slots[kept] = sched_slots[k];
                        kept++;
                    end
                end
                sched_count = kept;
            end
            OP_SET_TIME: begin
                sched_now = tm;
            end
            OP_REBASE: begin
                if (sched_count > 0) begin
                    head_time = sched_slots[0].tm;
                    for (int k = 0; k < sched_count; k++)
                        sched_slots[k].tm = sched_slots[k].tm - head_time;
                end
                sched_now = '0;
            end
            default: begin
            end
        endcase
        res.removed = CNT_W'(dropped);
        res.now     = sched_now;
        res.occ     = CNT_W'(sched_count);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endtask

    // Results cannot be held off, so each cycle with o_done high is checked
    // against the oldest expected result.
    always @(posedge i_clk) begin : result_check
        t_queue_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result arrived with no request outstanding");
                failures++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, o_status);
                check_field("popped_tag", want.tag, o_popped_tag);
                check_field("popped_time", want.tm, o_popped_time);
                check_field("popped_owner", want.owner, o_popped_owner);
                check_field("removed_count", want.removed, o_removed_count);
                check_field("now_time", want.now, o_now_time);
                check_field("occupancy", want.occ, o_occupancy);
            end
        end
    end

    // Offer one request and wait until the block takes it. The task is entered
    // and left at a rising edge. On return, start is still high. The next request
    // either replaces the payload at once or lowers start for a gap. This way
    // start gets only one assignment in any time step.
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic [TIME_BITS-1:0] tm,
                                input logic [TAG_BITS-1:0] tag,
                                input logic [OWNER_BITS-1:0] owner);
        t_queue_result res;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_opcode     <= op;
        i_event_time <= tm;
        i_event_tag  <= tag;
        i_owner_id   <= owner;
        @(posedge i_clk);
        // busy is read here as it stood before this edge. That is the value the
        // block used to decide whether it accepted the request.
        while (busy)
            @(posedge i_clk);
        schedule_request(op, tm, tag, owner, res);
        pending_results = {pending_results, res};
    endtask

    // Stop sending and wait until every outstanding result has arrived. With
    // nothing outstanding, start is already low and is left alone.
    task automatic wait_drained(input int settle);
        if (pending_results.size() != 0) begin
            start <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge i_clk);
        end
        repeat (settle) @(posedge i_clk);
    endtask

    function automatic logic [OWNER_BITS-1:0] pick_owner();
        if ($urandom_range(99) < 85)
            return owner_pool[$urandom_range(5)];
        return $urandom;
    endfunction

    // Pick times that are near the current time, anywhere in the range, near either end
    // of the range, or equal to the time of an entry already queued.
    function automatic logic [TIME_BITS-1:0] pick_time();
        case ($urandom_range(5))
            0, 1: return sched_now + $urandom_range(200);
            2:    return $urandom;
            3:    return 32'hFFFF_FFFF - $urandom_range(100);
            4:    return $urandom_range(100);
            default: begin
                if (sched_count > 0)
                    return sched_slots[$urandom_range(sched_count - 1)].tm;
                return sched_now;
            end
        endcase
    endfunction

    // The directed cases cover these situations:
    // - a pop and a rebase on an empty queue;
    // - inserts at the extremes of time, tag and owner;
    // - entries with the same time leaving in arrival order;
    // - a due pop that does not move the clock backwards;
    // - a pop with nothing due that does move the clock backwards;
    // - removes that hit and that miss;
    // - a rebase on a queue that holds entries;
    // - both spare opcodes.
    task automatic test_directed();
        logic [OWNER_BITS-1:0] owner_a;
        logic [OWNER_BITS-1:0] owner_b;
        owner_a = 32'h0000_00A5;
        owner_b = 32'h5A5A_0001;
        idle_pct = 0;
        send_request(OP_POP, 32'd100, 16'h0000, 32'h0);
        send_request(OP_REBASE, 32'h0, 16'h0, 32'h0);
        send_request(OP_SET_TIME, 32'hFFFF_FFFF, 16'h0, 32'h0);
        send_request(OP_INS_NOW, 32'h0, 16'h0001, owner_a);
        send_request(OP_INS_TIMED, 32'h0, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(OP_INS_TIMED, 32'h0, 16'h0000, 32'h0);
        send_request(OP_INS_TIMED, 32'd500, 16'h0002, owner_a);
        // Both zero-time entries are due. The clock stays at its maximum.
        send_request(OP_POP, 32'h0, 16'h0, 32'h0);
        send_request(OP_POP, 32'h0, 16'h0, 32'h0);
        // This target is just short of the head, so nothing is due.
        send_request(OP_POP, 32'd499, 16'h0, 32'h0);
        send_request(OP_INS_TIMED, 32'd499, 16'h0003, owner_b);
        send_request(OP_REMOVE, 32'h0, 16'h0, owner_a);
        send_request(OP_REMOVE, 32'h0, 16'h0, 32'h0001_2345);
        send_request(OP_INS_TIMED, 32'd1000, 16'h0004, owner_b);
        send_request(OP_INS_TIMED, 32'd1000, 16'h0005, 32'h0);
        send_request(OP_REBASE, 32'h0, 16'h0, 32'h0);
        send_request(OP_SPARE_6, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(OP_SPARE_7, 32'h1234_5678, 16'h9ABC, 32'hDEF0_1234);
        send_request(OP_POP, 32'hFFFF_FFFF, 16'h0, 32'h0);
        send_request(OP_POP, 32'hFFFF_FFFF, 16'h0, 32'h0);
        send_request(OP_POP, 32'hFFFF_FFFF, 16'h0, 32'h0);
        send_request(OP_POP, 32'h0, 16'h0, 32'h0);
        wait_drained(0);
    endtask

    // Fill the queue, insert into it while it is full, rebase it, and empty it
    // with a single remove. Then fill it again and pop it dry.
    task automatic test_full_queue();
        logic [OWNER_BITS-1:0] crowd_owner;
        crowd_owner = 32'h8000_0001;
        idle_pct = 0;
        send_request(OP_SET_TIME, 32'd1000, 16'h0, 32'h0);
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_request((i % 4 == 3) ? OP_INS_NOW : OP_INS_TIMED,
                         $urandom_range(2000), TAG_BITS'($urandom), crowd_owner);
        send_request(OP_INS_TIMED, 32'd5, 16'h1234, 32'd7);
        send_request(OP_INS_NOW, 32'h0, 16'h4321, 32'd7);
        send_request(OP_REBASE, 32'h0, 16'h0, 32'h0);
        send_request(OP_REMOVE, 32'h0, 16'h0, crowd_owner);
        idle_pct = 20;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_request(OP_INS_TIMED, $urandom_range(300), TAG_BITS'($urandom),
                         owner_pool[i % 6]);
        for (int i = 0; i <= QUEUE_DEPTH; i++)
            send_request(OP_POP, 32'hFFFF_FFFF, TAG_BITS'($urandom), $urandom);
        wait_drained(0);
    endtask

    // Build one random request. Most pops and removes are shaped from the current queue
    // contents: pops aimed at the head and removes of owners that are present.
    // The op mix alternates between filling and draining the queue, so that
    // occupancy moves over the whole range. The output is low for a spare
    // opcode, because the block ignores those.
    task automatic random_request(input bit filling, output bit counted);
        int                    roll;
        logic [OP_W-1:0]       op;
        logic [TIME_BITS-1:0]  tm;
        logic [TAG_BITS-1:0]   tag;
        logic [OWNER_BITS-1:0] owner;

        roll    = $urandom_range(99);
        tm      = pick_time();
        tag     = TAG_BITS'($urandom);
        owner   = pick_owner();
        counted = 1'b1;
        if (roll < (filling ? 55 : 20)) begin
            op = OP_INS_TIMED;
        end else if (roll < (filling ? 65 : 27)) begin
            op = OP_INS_NOW;
        end else if (roll < (filling ? 78 : 75)) begin
            op = OP_POP;
            if (sched_count > 0) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: tm = sched_slots[0].tm + $urandom_range(50);
                    5, 6:          tm = sched_slots[0].tm - 1;
                    default: begin
                    end
                endcase
            end
        end else if (roll < 85) begin
            op = OP_REMOVE;
            if (sched_count > 0 && $urandom_range(3) != 0)
                owner = sched_slots[$urandom_range(sched_count - 1)].owner;
        end else if (roll < 92) begin
            op = OP_SET_TIME;
        end else if (roll < 98) begin
            op = OP_REBASE;
        end else begin
            op      = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
            counted = 1'b0;
        end
        send_request(op, tm, tag, owner);
    endtask

    task automatic test_random_traffic(input int pct, input int count);
        int  done_count;
        bit  filling;
        bit  counted;
        done_count = 0;
        filling    = 1'b1;
        idle_pct   = pct;
        while (done_count < count) begin
            if ($urandom_range(79) == 0)
                filling = ~filling;
            random_request(filling, counted);
            if (counted)
                done_count++;
            // Now and then the sender waits until all results are in. The next
            // request then reaches a block that has been idle.
            if ($urandom_range(49) == 0)
                wait_drained(0);
        end
        wait_drained(0);
    endtask

    initial begin
        owner_pool[0] = 32'h0;
        owner_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 6; i++)
            owner_pool[i] = $urandom;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_queue();
        test_random_traffic(0, 250);
        test_random_traffic(88, 200);
        test_random_traffic(32, 250);
        test_random_traffic(0, 100);

        wait_drained(SETTLE_CYCLES);
        if (failures == 0)
            $display("timed_event_queue: match");
        else
            $display("timed_event_queue: mismatch");
        $finish;
    end

    // This is a watchdog for a block that hangs or stops answering.
    initial begin
        #(5_000_000);
        $display("timed_event_queue: mismatch");
        $finish;
    end

endmodule
